### design/rgm_pkg.sv
// rgm_pkg: shared types, constants and helper functions for the ramped gain stage
// used by rgm_mul and ramped_gain_with_mute, depends on nothing

package rgm_pkg;

  // field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 15;
  localparam int unsigned StepsW  = 16;

  // shared multiplier operand and product widths
  localparam int unsigned MulAW  = 17;
  localparam int unsigned MulBW  = 32;
  localparam int unsigned ProdW  = MulAW + MulBW;

  // q16 multiplier: trunc(|g| * 65536 / 1000) = trunc(|g| * 8192 / 125)
  // done as (|g| * RecipC) >> RecipShift, exact for |g| up to 16384
  localparam int unsigned RecipShift = 24;
  localparam int unsigned MultW      = 21;
  localparam logic [30:0] RecipC     = 31'd1099511628;

  // product to sample scaling
  localparam int unsigned QShift = 16;

  // gain limits in thousandths
  localparam logic signed [GainW:0] GainMin = -16'sd16384;
  localparam logic signed [GainW:0] GainMax = 16'sd16383;

  // smallest distance that still starts a ramp is one above this
  localparam logic [StepsW-1:0] RampMinDist = 16'd2;
  localparam logic [StepsW-1:0] StepsPerPair = 16'd2;

  localparam logic signed [GainW-1:0] GainUnity = 15'sd1000;

  typedef enum logic [1:0] {
    FUNC_PAIR   = 2'd0,
    FUNC_SET    = 2'd1,
    FUNC_MUTE   = 2'd2,
    FUNC_UNMUTE = 2'd3
  } func_e;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RECIP = 6'b000010,
    ST_NORM  = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_SAT   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  // one ramp step, clamped to the signed gain range
  function automatic logic signed [GainW-1:0] step_gain(
    input logic signed [GainW-1:0] g,
    input logic                    down
  );
    logic signed [GainW:0] s;
    s = down ? ({g[GainW-1], g} - 16'sd1) : ({g[GainW-1], g} + 16'sd1);
    if (s < GainMin) begin
      s = GainMin;
    end else if (s > GainMax) begin
      s = GainMax;
    end
    return s[GainW-1:0];
  endfunction

  // floor shift right by 16 and saturate to the sample range
  function automatic logic signed [SampleW-1:0] sat_sample(
    input logic signed [ProdW-1:0] p
  );
    logic signed [ProdW-QShift-1:0] q;
    logic signed [SampleW-1:0]      r;
    q = p[ProdW-1:QShift];
    if (q > $signed({{(ProdW-QShift-SampleW+1){1'b0}}, {(SampleW-1){1'b1}}})) begin
      r = {1'b0, {(SampleW-1){1'b1}}};
    end else if (q < $signed({{(ProdW-QShift-SampleW+1){1'b1}}, {(SampleW-1){1'b0}}})) begin
      r = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      r = q[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

### design/rgm_mul.sv
// rgm_mul: shared signed multiplier with a registered product
// depends on rgm_pkg for operand and product widths

module rgm_mul import rgm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [MulAW-1:0] a_i,
  input  logic signed [MulBW-1:0] b_i,
  output logic signed [ProdW-1:0] prod_o
);

  logic signed [ProdW-1:0] prod_q;

  // product register, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdW'(a_i) * ProdW'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

### design/ramped_gain_with_mute.sv
// ramped_gain_with_mute: zipper-free gain stage with linear ramps and mute.
// A set gain, mute or unmute transaction is taken in the idle state and gives no result. A sample
// pair runs through RECIP, NORM, SCALE, SAT, SCALE and DONE, with RECIP and NORM again after SAT
// while ramping; the one shared multiplier forms each q16 gain and then scales each sample. No new
// transaction is taken until the pair is done. A finished result waits in the output register while
// the next transaction is taken, and a pair holds in DONE while that register is full and stalled.
// Asynchronous active-low reset: gain and saved gain 1000, no ramp, no result pending.

module ramped_gain_with_mute import rgm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                func_i,
  input  logic signed [SampleW-1:0] sample_low_i,
  input  logic signed [SampleW-1:0] sample_high_i,
  input  logic signed [GainW-1:0]   target_gain_milli_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] out_low_o,
  output logic signed [SampleW-1:0] out_high_o,
  output logic                      ramping_o
);

  state_e                    state_q, state_d;
  logic signed [GainW-1:0]   gain_q, gain_d;
  logic signed [GainW-1:0]   saved_q, saved_d;
  logic                      ramp_active_q, ramp_active_d;
  logic                      ramp_down_q, ramp_down_d;
  logic [StepsW-1:0]         steps_q, steps_d;
  logic                      phase_q, phase_d;
  logic                      neg_q, neg_d;
  logic signed [MultW:0]     mult_q, mult_d;
  logic signed [SampleW-1:0] hi_res_q, hi_res_d;
  logic signed [SampleW-1:0] s_lo_q, s_hi_q;
  logic                      out_valid_q, out_valid_d;
  logic signed [SampleW-1:0] out_low_q, out_low_d;
  logic signed [SampleW-1:0] out_high_q, out_high_d;
  logic                      ramping_q, ramping_d;

  logic                      in_accept;
  logic                      mul_en;
  logic signed [MulAW-1:0]   mul_a;
  logic signed [MulBW-1:0]   mul_b;
  logic signed [ProdW-1:0]   prod;
  logic [GainW:0]            gain_mag;
  logic [MultW-1:0]          mult_mag;
  logic signed [GainW-1:0]   ramp_target;
  logic signed [GainW:0]     diff;
  logic [StepsW-1:0]         gain_dist;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);

  // magnitude of the current gain and of the reciprocal product
  assign gain_mag = gain_q[GainW-1] ? (-{gain_q[GainW-1], gain_q}) : {gain_q[GainW-1], gain_q};
  assign mult_mag = prod[RecipShift+MultW-1:RecipShift];

  // operand selection for the shared multiplier
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      ST_RECIP: begin
        mul_en = 1'b1;
        mul_a  = MulAW'(gain_mag);
        mul_b  = MulBW'(RecipC);
      end
      ST_SCALE: begin
        mul_en = 1'b1;
        mul_a  = phase_q ? MulAW'(s_lo_q) : MulAW'(s_hi_q);
        mul_b  = MulBW'(mult_q);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  rgm_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // ramp target and distance for control transactions
  always_comb begin
    case (func_e'(func_i))
      FUNC_SET:    ramp_target = target_gain_milli_i;
      FUNC_UNMUTE: ramp_target = saved_q;
      default:     ramp_target = '0;
    endcase
    diff = {ramp_target[GainW-1], ramp_target} - {gain_q[GainW-1], gain_q};
    gain_dist = diff[GainW] ? StepsW'(-diff) : StepsW'(diff);
  end

  // sequencer and state updates
  always_comb begin
    state_d       = state_q;
    gain_d        = gain_q;
    saved_d       = saved_q;
    ramp_active_d = ramp_active_q;
    ramp_down_d   = ramp_down_q;
    steps_d       = steps_q;
    phase_d       = phase_q;
    neg_d         = neg_q;
    mult_d        = mult_q;
    hi_res_d      = hi_res_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_low_d     = out_low_q;
    out_high_d    = out_high_q;
    ramping_d     = ramping_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (func_e'(func_i) == FUNC_PAIR) begin
            phase_d = 1'b0;
            if (ramp_active_q) begin
              gain_d = step_gain(gain_q, ramp_down_q);
            end
            state_d = ST_RECIP;
          end else begin
            if (func_e'(func_i) == FUNC_MUTE) begin
              saved_d = gain_q;
            end
            if (gain_dist > RampMinDist) begin
              ramp_active_d = 1'b1;
              ramp_down_d   = diff[GainW];
              steps_d       = {gain_dist[StepsW-1:1], 1'b0};
            end
          end
        end
      end
      ST_RECIP: begin
        neg_d   = gain_q[GainW-1];
        state_d = ST_NORM;
      end
      ST_NORM: begin
        mult_d  = neg_q ? (-{1'b0, mult_mag}) : {1'b0, mult_mag};
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        state_d = phase_q ? ST_DONE : ST_SAT;
      end
      ST_SAT: begin
        // high sample done, second step for the low sample
        hi_res_d = sat_sample(prod);
        phase_d  = 1'b1;
        if (ramp_active_q) begin
          gain_d  = step_gain(gain_q, ramp_down_q);
          state_d = ST_RECIP;
        end else begin
          state_d = ST_SCALE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          if (ramp_active_q) begin
            if (steps_q <= StepsPerPair) begin
              steps_d       = '0;
              ramp_active_d = 1'b0;
            end else begin
              steps_d = steps_q - StepsPerPair;
            end
          end
          out_low_d   = sat_sample(prod);
          out_high_d  = hi_res_q;
          ramping_d   = ramp_active_q && (steps_q > StepsPerPair);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and gain state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      gain_q        <= GainUnity;
      saved_q       <= GainUnity;
      ramp_active_q <= 1'b0;
      ramp_down_q   <= 1'b0;
      steps_q       <= '0;
      phase_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      gain_q        <= gain_d;
      saved_q       <= saved_d;
      ramp_active_q <= ramp_active_d;
      ramp_down_q   <= ramp_down_d;
      steps_q       <= steps_d;
      phase_q       <= phase_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s_lo_q <= sample_low_i;
      s_hi_q <= sample_high_i;
    end
    neg_q      <= neg_d;
    mult_q     <= mult_d;
    hi_res_q   <= hi_res_d;
    out_low_q  <= out_low_d;
    out_high_q <= out_high_d;
    ramping_q  <= ramping_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_low_o   = out_low_q;
  assign out_high_o  = out_high_q;
  assign ramping_o   = ramping_q;

endmodule

### sim/ramped_gain_with_mute_test.sv
// ramped_gain_with_mute_test: self-checking bench for the ramped gain stage
// drives sample pairs and gain commands, predicts each scaled pair and checks it
// depends on rgm_pkg and ramped_gain_with_mute

module ramped_gain_with_mute_test;
  import rgm_pkg::*;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned RandomItems = 700;
  localparam int unsigned DrainCycles = 40;

  typedef struct {
    logic signed [SampleW-1:0] out_low;
    logic signed [SampleW-1:0] out_high;
    logic                      ramping;
  } scaled_pair_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                func_i = FUNC_PAIR;
  logic signed [SampleW-1:0] sample_low_i = '0;
  logic signed [SampleW-1:0] sample_high_i = '0;
  logic signed [GainW-1:0]   target_gain_milli_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [SampleW-1:0] out_low_o;
  logic signed [SampleW-1:0] out_high_o;
  logic                      ramping_o;

  // expected scaled pairs, oldest first
  scaled_pair_t expected_pairs[$];
  scaled_pair_t head_pair;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  stall_left = 0;
  bit           calm = 1'b0;

  // gain stage state as the bench sees it
  int          gain_now = 1000;
  int          gain_saved = 1000;
  bit          ramp_on = 1'b0;
  bit          ramp_dn = 1'b0;
  int unsigned steps_to_go = 0;

  ramped_gain_with_mute uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .func_i             (func_i),
    .sample_low_i       (sample_low_i),
    .sample_high_i      (sample_high_i),
    .target_gain_milli_i(target_gain_milli_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_low_o          (out_low_o),
    .out_high_o         (out_high_o),
    .ramping_o          (ramping_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // q16 multiplier of a gain in thousandths, truncated toward zero
  function automatic longint gain_to_mult(int g);
    longint mag;
    longint m;
    mag = (g < 0) ? -longint'(g) : longint'(g);
    m = (mag * 65536) / 1000;
    return (g < 0) ? -m : m;
  endfunction

  // floor shift by 16 and saturate to a sample
  function automatic logic signed [SampleW-1:0] scale_sample(int s, longint m);
    longint p;
    longint q;
    p = longint'(s) * m;
    q = p >>> 16;
    if (q > 32767) begin
      q = 32767;
    end else if (q < -32768) begin
      q = -32768;
    end
    return q[SampleW-1:0];
  endfunction

  // a command ramps only when the distance is more than two
  function automatic void begin_ramp(int target);
    int diff;
    int distance;
    diff = target - gain_now;
    distance = (diff < 0) ? -diff : diff;
    if (distance > 2) begin
      ramp_on = 1'b1;
      ramp_dn = (diff < 0);
      steps_to_go = (distance & ~1) & 32'hffff;
    end
  endfunction

  // one ramp step, clamped to the gain range
  function automatic int step_gain_now();
    gain_now = gain_now + (ramp_dn ? -1 : 1);
    if (gain_now < -16384) begin
      gain_now = -16384;
    end else if (gain_now > 16383) begin
      gain_now = 16383;
    end
    return gain_now;
  endfunction

  // update the gain state for one transaction and, for a sample pair, queue its scaled pair
  task automatic predict_gain_stage(func_e f, logic signed [SampleW-1:0] lo,
                                    logic signed [SampleW-1:0] hi,
                                    logic signed [GainW-1:0] tgt);
    longint       m_first;
    longint       m_second;
    scaled_pair_t pair;
    case (f)
      FUNC_SET: begin
        begin_ramp(int'(tgt));
      end
      FUNC_MUTE: begin
        gain_saved = gain_now;
        begin_ramp(0);
      end
      FUNC_UNMUTE: begin
        begin_ramp(gain_saved);
      end
      default: begin
        if (ramp_on) begin
          m_first = gain_to_mult(step_gain_now());
          m_second = gain_to_mult(step_gain_now());
          if (steps_to_go <= 2) begin
            steps_to_go = 0;
            ramp_on = 1'b0;
          end else begin
            steps_to_go = steps_to_go - 2;
          end
        end else begin
          m_first = gain_to_mult(gain_now);
          m_second = m_first;
        end
        pair.out_low = scale_sample(int'(lo), m_second);
        pair.out_high = scale_sample(int'(hi), m_first);
        pair.ramping = ramp_on;
        expected_pairs.push_back(pair);
      end
    endcase
  endtask

  // input gap: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // one input transaction, payload held until taken
  task automatic send_item(func_e f, logic signed [SampleW-1:0] lo,
                           logic signed [SampleW-1:0] hi, logic signed [GainW-1:0] tgt);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    sample_low_i <= lo;
    sample_high_i <= hi;
    target_gain_milli_i <= tgt;
    do @(posedge clk_i); while (in_stall_o);
    predict_gain_stage(f, lo, hi, tgt);
  endtask

  task automatic send_pair(logic signed [SampleW-1:0] lo, logic signed [SampleW-1:0] hi);
    send_item(FUNC_PAIR, lo, hi, GainW'($urandom_range(0, 32767)));
  endtask

  task automatic send_cmd(func_e f, int tgt);
    send_item(f, SampleW'($urandom_range(0, 65535)), SampleW'($urandom_range(0, 65535)),
              tgt[GainW-1:0]);
  endtask

  // hold off input until every pending pair has come back
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_pairs.size() != 0);
  endtask

  task automatic note_mismatch(string what, scaled_pair_t want, scaled_pair_t got);
    if (mismatch_count < 10) begin
      $display("mismatch %s: expected low %0d high %0d ramping %0b, got %0d %0d %0b",
               what, want.out_low, want.out_high, want.ramping,
               got.out_low, got.out_high, got.ramping);
    end
    mismatch_count++;
  endtask

  // result check and output stall
  always @(posedge clk_i) begin
    scaled_pair_t got;
    got.out_low = out_low_o;
    got.out_high = out_high_o;
    got.ramping = ramping_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pairs.size() == 0) begin
        head_pair = '{default: '0};
        note_mismatch("unexpected transaction", head_pair, got);
      end else begin
        head_pair = expected_pairs.pop_front();
        if (got.out_low !== head_pair.out_low || got.out_high !== head_pair.out_high ||
            got.ramping !== head_pair.ramping) begin
          note_mismatch("field", head_pair, got);
        end
      end
    end
    // stall pattern: mostly free, short bursts, rare long holds
    if (!rst_ni || calm) begin
      stall_left <= 0;
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0: begin
          stall_left <= $urandom_range(8, 30);
          out_stall_i <= 1'b1;
        end
        1, 2, 3, 4: begin
          stall_left <= $urandom_range(0, 2);
          out_stall_i <= 1'b1;
        end
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return $urandom_range(0, 1) ? 16'sh0001 : 16'shffff;
      3, 4: return SampleW'($urandom_range(0, 511) - 256);
      default: return SampleW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int pick_target();
    int r;
    int t;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      t = gain_now + int'($urandom_range(0, 80)) - 40;
    end else if (r < 90) begin
      t = int'($urandom_range(0, 32766)) - 16383;
    end else begin
      case ($urandom_range(0, 2))
        0: t = 16383;
        1: t = -16383;
        default: t = 0;
      endcase
    end
    if (t > 16383) begin
      t = 16383;
    end else if (t < -16383) begin
      t = -16383;
    end
    return t;
  endfunction

  // extremes of the samples and of the gain, every command, ramp edges
  task automatic test_directed();
    send_pair(16'sh7fff, 16'sh8000);
    send_pair(16'sh8000, 16'sh7fff);
    send_pair(16'shffff, 16'sh0001);
    // shortest ramp, over after one pair
    send_cmd(FUNC_SET, 1003);
    send_pair(16'sd12345, -16'sd12345);
    // distance of two or less leaves the gain alone
    send_cmd(FUNC_SET, 1004);
    send_pair(16'sh4000, 16'shc000);
    send_cmd(FUNC_SET, 1001);
    send_cmd(FUNC_MUTE, 0);
    send_pair(16'sh7fff, 16'sh8000);
    // new ramp replaces the running one
    send_cmd(FUNC_SET, 16383);
    send_pair(16'sh7fff, 16'sh8000);
    send_pair(16'sh0001, 16'shffff);
    send_cmd(FUNC_SET, -16383);
    send_pair(16'sh8000, 16'sh7fff);
    send_pair(16'sh7fff, 16'sh8000);
    send_cmd(FUNC_UNMUTE, 0);
    send_pair(16'sh5555, 16'shaaaa);
    send_cmd(FUNC_SET, 0);
    send_pair(16'sh0000, 16'sh0000);
  endtask

  // run a mute ramp to its end, then commands close to the current gain and a long ramp that an unmute replaces
  task automatic test_mute_cycle();
    int guard;
    guard = 0;
    send_cmd(FUNC_MUTE, 0);
    while (ramp_on && guard < 2000) begin
      send_pair(pick_sample(), pick_sample());
      guard++;
    end
    send_pair(16'sh7fff, 16'sh8000);
    send_cmd(FUNC_MUTE, 0);
    send_cmd(FUNC_UNMUTE, 0);
    send_cmd(FUNC_SET, 2);
    send_cmd(FUNC_SET, 3);
    send_pair(16'sh7fff, 16'sh8000);
    send_cmd(FUNC_MUTE, 0);
    send_cmd(FUNC_UNMUTE, 0);
    send_cmd(FUNC_SET, 1500);
    repeat (3) send_pair(pick_sample(), pick_sample());
    send_cmd(FUNC_UNMUTE, 0);
    repeat (2) send_pair(pick_sample(), pick_sample());
  endtask

  // random mix, mostly pairs, with calm stretches and one full drain
  task automatic test_random();
    int unsigned r;
    for (int i = 0; i < RandomItems; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        calm = ~calm;
      end
      if (i == RandomItems / 2) begin
        wait_results_done();
      end
      r = $urandom_range(0, 99);
      if (r < 74) begin
        send_pair(pick_sample(), pick_sample());
      end else if (r < 88) begin
        send_cmd(FUNC_SET, pick_target());
      end else if (r < 94) begin
        send_cmd(FUNC_MUTE, 0);
      end else begin
        send_cmd(FUNC_UNMUTE, 0);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_mute_cycle();
    test_random();
    wait_results_done();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_pairs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
design/rgm_pkg.sv
design/rgm_mul.sv
design/ramped_gain_with_mute.sv
sim/ramped_gain_with_mute_test.sv
